FILE: design/dfs_pkg.sv
package dfs_pkg;

    typedef logic [4:0]  vertex_t;
    typedef logic [31:0] row_t;
    typedef logic [5:0]  count_t;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    localparam int VERTEX_W = 5;
    localparam int ROW_W    = 32;

    typedef struct packed {
        logic    cmd;
        vertex_t row_index;
        row_t    row_bits;
        vertex_t start_vertex;
    } item_t;

    typedef struct packed {
        vertex_t visit_vertex;
        logic    bad_start;
        logic    last;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ROW  = 3'b010,
        S_POP  = 3'b100
    } state_t;

    // Encode a one-hot row word into its bit position; each output bit is an
    // independent OR over the positions that have that bit set.
    function automatic vertex_t onehot_index(input row_t onehot);
        vertex_t idx;
        idx = '0;
        for (int b = 0; b < VERTEX_W; b++)
        begin
            for (int i = 0; i < ROW_W; i++)
            begin
                if (((i >> b) & 1) == 1)
                begin
                    idx[b] = idx[b] | onehot[i];
                end
            end
        end
        return idx;
    endfunction

endpackage

FILE: design/dfs_ram.sv
module dfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/depth_first_search_order_unit.sv
// Channel    Direction  Handshake                   Payload
// command    in         start / busy                item   (dfs_pkg::item_t)
// config     in         cfg_valid / cfg_ready       cfg_data (vertex count)
// result     out        strobe, one cycle, no stall result (dfs_pkg::result_t)
//
// A row load writes one adjacency memory row. A search reads the adjacency
// memory for each push (the row of the new top) and, for each pop, reads the
// stack memory, then the adjacency memory (the row of the vertex below).
// Each result leaves one push later than its discovery, so that the final
// one can carry last. Reset clears control state and the visited marks;
// the memories need no clearing. The receiver cannot stall results.
module depth_first_search_order_unit #(
    parameter int MAX_VERTICES = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  dfs_pkg::item_t    item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  dfs_pkg::count_t   cfg_data,
    output logic              strobe,
    output dfs_pkg::result_t  result
);

    localparam int LIMIT = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int DW    = $clog2(MAX_VERTICES + 1);

    dfs_pkg::state_t   state_reg, state_next;
    dfs_pkg::count_t   vertex_count_reg;
    dfs_pkg::row_t     visited_reg, visited_next;
    dfs_pkg::row_t     range_mask_reg, range_mask_next;
    logic [DW-1:0]     depth_reg, depth_next;
    dfs_pkg::vertex_t  pend_reg, pend_next;
    logic              strobe_reg, strobe_next;
    dfs_pkg::result_t  result_reg, result_next;

    logic              accept;
    dfs_pkg::count_t   count;
    dfs_pkg::row_t     range_mask;
    logic              start_bad;
    logic              load_ok;

    logic              adj_we;
    logic [AW-1:0]     adj_waddr;
    logic [AW-1:0]     adj_raddr;
    dfs_pkg::row_t     adj_rdata;

    logic              stk_we;
    logic [AW-1:0]     stk_waddr;
    dfs_pkg::vertex_t  stk_wdata;
    logic [AW-1:0]     stk_raddr;
    dfs_pkg::vertex_t  stk_rdata;

    dfs_pkg::row_t     cand;
    dfs_pkg::row_t     lowest;
    logic              found;
    dfs_pkg::vertex_t  next_vertex;
    logic              can_push;

    assign busy      = (state_reg != dfs_pkg::S_IDLE);
    // Hold off a count write while busy or while a command transaction is offered.
    assign cfg_ready = (state_reg == dfs_pkg::S_IDLE) && !start;
    assign accept    = start && !busy;
    assign strobe    = strobe_reg;
    assign result    = result_reg;

    // Active vertex count saturates at the smaller of 32 and the stack depth.
    assign count = (vertex_count_reg > 6'(LIMIT)) ? 6'(LIMIT) : vertex_count_reg;

    always_comb
    begin
        for (int i = 0; i < dfs_pkg::ROW_W; i++)
        begin
            range_mask[i] = (6'(i) < count);
        end
    end

    assign start_bad = ({1'b0, item.start_vertex} >= count);
    assign load_ok   = ({27'd0, item.row_index} < 32'(MAX_VERTICES));

    // Lowest unvisited neighbor of the current top: isolate the lowest set bit.
    assign cand        = adj_rdata & range_mask_reg & ~visited_reg;
    assign lowest      = cand & (~cand + 32'd1);
    assign found       = |cand;
    assign next_vertex = dfs_pkg::onehot_index(lowest);
    assign can_push    = found && (depth_reg < DW'(MAX_VERTICES));

    assign adj_we    = accept && (item.cmd == dfs_pkg::CMD_LOAD) && load_ok;
    assign adj_waddr = AW'(item.row_index);

    always_comb
    begin
        state_next      = state_reg;
        visited_next    = visited_reg;
        range_mask_next = range_mask_reg;
        depth_next      = depth_reg;
        pend_next       = pend_reg;
        strobe_next     = 1'b0;
        result_next     = result_reg;
        adj_raddr       = '0;
        stk_we          = 1'b0;
        stk_waddr       = depth_reg[AW-1:0];
        stk_wdata       = next_vertex;
        stk_raddr       = '0;

        case (state_reg)
            dfs_pkg::S_IDLE:
            begin
                if (accept && (item.cmd == dfs_pkg::CMD_SEARCH))
                begin
                    depth_next = '0;
                    if (start_bad)
                    begin
                        visited_next = '0;
                        strobe_next  = 1'b1;
                        result_next  = '{visit_vertex: '0, bad_start: 1'b1, last: 1'b1};
                    end
                    else
                    begin
                        visited_next    = 32'd1 << item.start_vertex;
                        range_mask_next = range_mask;
                        depth_next      = DW'(1);
                        pend_next       = item.start_vertex;
                        stk_we          = 1'b1;
                        stk_waddr       = '0;
                        stk_wdata       = item.start_vertex;
                        adj_raddr       = AW'(item.start_vertex);
                        state_next      = dfs_pkg::S_ROW;
                    end
                end
            end
            dfs_pkg::S_ROW:
            begin
                if (can_push)
                begin
                    // Release the held result; the new vertex becomes the held one.
                    strobe_next  = 1'b1;
                    result_next  = '{visit_vertex: pend_reg, bad_start: 1'b0, last: 1'b0};
                    pend_next    = next_vertex;
                    visited_next = visited_reg | lowest;
                    stk_we       = 1'b1;
                    depth_next   = depth_reg + DW'(1);
                    adj_raddr    = AW'(next_vertex);
                end
                else
                begin
                    depth_next = depth_reg - DW'(1);
                    if (depth_reg == DW'(1))
                    begin
                        strobe_next = 1'b1;
                        result_next = '{visit_vertex: pend_reg, bad_start: 1'b0, last: 1'b1};
                        state_next  = dfs_pkg::S_IDLE;
                    end
                    else
                    begin
                        // Fetch the vertex below the popped top.
                        stk_raddr  = AW'(depth_reg - DW'(2));
                        state_next = dfs_pkg::S_POP;
                    end
                end
            end
            dfs_pkg::S_POP:
            begin
                adj_raddr  = AW'(stk_rdata);
                state_next = dfs_pkg::S_ROW;
            end
            default:
            begin
                state_next = dfs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= dfs_pkg::S_IDLE;
            vertex_count_reg <= 6'd32;
            visited_reg      <= '0;
            depth_reg        <= '0;
            strobe_reg       <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            visited_reg <= visited_next;
            depth_reg   <= depth_next;
            strobe_reg  <= strobe_next;
            if (cfg_valid && cfg_ready)
            begin
                vertex_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        range_mask_reg <= range_mask_next;
        pend_reg       <= pend_next;
        result_reg     <= result_next;
    end

    dfs_ram #(
        .WIDTH (dfs_pkg::ROW_W),
        .DEPTH (MAX_VERTICES)
    ) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (item.row_bits),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    dfs_ram #(
        .WIDTH (dfs_pkg::VERTEX_W),
        .DEPTH (MAX_VERTICES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && result_reg.bad_start |-> result_reg.last)
        else $error("bad start result without last");

    a_last_ends_search: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && result_reg.last |-> state_reg == dfs_pkg::S_IDLE)
        else $error("last result while search still running");

    a_row_has_top: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dfs_pkg::S_ROW |-> depth_reg != '0)
        else $error("row step with empty stack");

    a_visited_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (visited_reg & ~range_mask_reg) == '0)
        else $error("visited mark outside active vertex range");

    a_push_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dfs_pkg::S_ROW && stk_we |-> depth_reg < DW'(MAX_VERTICES))
        else $error("stack push beyond depth");

endmodule

FILE: bench/tb.sv
module tb;
    import dfs_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES = 120;
    localparam int MAX_ERR_LINES = 50;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    item_t    item = '0;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    count_t   cfg_data = '0;
    logic     strobe;
    result_t  result;

    // stimulus side: items waiting for the driver, plus a mirror of the rows
    // so that no search ever walks into a row that was never loaded
    item_t        pending_items[$];
    row_t         gen_rows[32];
    logic [31:0]  gen_written = '0;
    int           gen_count = 32;
    int           queued_total = 0;

    // prediction side
    row_t         adj_rows[32];
    count_t       walk_count = 6'd32;
    result_t      visits_due[$];
    result_t      want;

    int           burst_left = 1;
    int           gap_left = 0;
    int           cycle_count = 0;
    int           error_count = 0;

    depth_first_search_order_unit #(
        .MAX_VERTICES(32)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .strobe(strobe),
        .result(result)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_ERR_LINES)
            $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got %0h, want %0h", name, got, exp_val));
    endtask

    // Walk the graph depth first from origin and queue the visits in preorder.
    task automatic predict_walk(input vertex_t origin);
        result_t      order[$];
        result_t      r;
        logic [31:0]  span;
        logic [31:0]  seen;
        logic [31:0]  cand;
        vertex_t      path[32];
        int           depth;
        int           lim;
        int           pick;
        lim = (walk_count > 32) ? 32 : int'(walk_count);
        r.bad_start = 1'b0;
        r.last = 1'b0;
        if (int'(origin) >= lim)
        begin
            r.visit_vertex = '0;
            r.bad_start = 1'b1;
            r.last = 1'b1;
            visits_due.push_back(r);
            return;
        end
        span = (lim >= 32) ? '1 : ((32'd1 << lim) - 32'd1);
        seen = 32'd1 << origin;
        path[0] = origin;
        depth = 1;
        r.visit_vertex = origin;
        order.push_back(r);
        while (depth > 0)
        begin
            cand = adj_rows[path[depth - 1]] & span & ~seen;
            pick = -1;
            for (int i = lim - 1; i >= 0; i--)
            begin
                if (cand[i])
                    pick = i;
            end
            if (pick >= 0 && depth < 32 && order.size() < 32)
            begin
                seen[pick] = 1'b1;
                path[depth] = vertex_t'(pick);
                depth++;
                r.visit_vertex = vertex_t'(pick);
                order.push_back(r);
            end
            else
            begin
                depth--;
            end
        end
        r = order.pop_back();
        r.last = 1'b1;
        order.push_back(r);
        foreach (order[k])
            visits_due.push_back(order[k]);
    endtask

    // Monitor: check results, then apply whatever was accepted at this edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (strobe)
            begin
                if (visits_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected visit of vertex %0d",
                                              result.visit_vertex));
                end
                else
                begin
                    want = visits_due.pop_front();
                    check_field("visit_vertex", 32'(result.visit_vertex),
                                32'(want.visit_vertex));
                    check_field("bad_start", 32'(result.bad_start), 32'(want.bad_start));
                    check_field("last", 32'(result.last), 32'(want.last));
                end
            end
            if (cfg_valid && cfg_ready)
                walk_count = cfg_data;
            if (start && !busy)
            begin
                if (item.cmd == CMD_LOAD)
                    adj_rows[item.row_index] = item.row_bits;
                else
                    predict_walk(item.start_vertex);
            end
        end
    end

    // Driver: bursts of transactions with random gaps in between.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            item <= '0;
            burst_left <= 1;
            gap_left <= 0;
        end
        else if (!start || !busy)
        begin
            if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_items.size() > 0)
            begin
                start <= 1'b1;
                item <= pending_items.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    function automatic row_t random_row();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return $urandom;
            4, 5: return row_t'(1) << $urandom_range(0, 31);
            default: return $urandom & $urandom & $urandom;
        endcase
    endfunction

    task automatic queue_load(input vertex_t index, input row_t bits);
        item_t it;
        it.cmd = CMD_LOAD;
        it.row_index = index;
        it.row_bits = bits;
        it.start_vertex = vertex_t'($urandom);
        gen_rows[index] = bits;
        gen_written[index] = 1'b1;
        pending_items.push_back(it);
        queued_total++;
    endtask

    // Load any reachable row that is still unwritten, then queue the search.
    task automatic queue_search(input vertex_t origin);
        item_t        it;
        logic [31:0]  span;
        logic [31:0]  reach;
        logic [31:0]  grown;
        bit           changed;
        if (int'(origin) < gen_count)
        begin
            span = (gen_count >= 32) ? '1 : ((32'd1 << gen_count) - 32'd1);
            reach = 32'd1 << origin;
            do
            begin
                grown = reach;
                for (int v = 0; v < 32; v++)
                begin
                    if (reach[v])
                    begin
                        if (!gen_written[v])
                            queue_load(vertex_t'(v), random_row());
                        grown |= gen_rows[v] & span;
                    end
                end
                changed = (grown != reach);
                reach = grown;
            end
            while (changed);
        end
        it.cmd = CMD_SEARCH;
        it.row_index = vertex_t'($urandom);
        it.row_bits = $urandom;
        it.start_vertex = origin;
        pending_items.push_back(it);
        queued_total++;
    endtask

    task automatic queue_random_phase(input int quota);
        int goal;
        goal = queued_total + quota;
        while (queued_total < goal)
        begin
            if ($urandom_range(0, 99) < 45)
                queue_load(vertex_t'($urandom), random_row());
            else if ($urandom_range(0, 9) == 0 || gen_count == 0)
                queue_search(vertex_t'($urandom));
            else
                queue_search(vertex_t'($urandom_range(0, gen_count - 1)));
        end
    endtask

    // Wait until every transaction is accepted and every visit has come back.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || start || visits_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        while (busy)
            @(negedge clk);
    endtask

    task automatic write_vertex_count(input count_t value);
        wait_idle();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        gen_count = (value > 32) ? 32 : int'(value);
        @(negedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // count left at its reset value
        queue_load(5'd31, '0);
        queue_search(5'd31);
        queue_load(5'd0, 32'h8000_0001);
        queue_search(5'd0);
        queue_load(5'd1, 32'h0000_000C);
        queue_load(5'd2, 32'h0000_0008);
        queue_load(5'd3, 32'h0000_0002);
        queue_search(5'd1);
        queue_search(5'd3);

        // edges past the count are dropped, starts past it are bad
        write_vertex_count(6'd3);
        queue_search(5'd0);
        queue_search(5'd2);
        queue_search(5'd1);
        queue_search(5'd3);
        queue_search(5'd31);

        write_vertex_count(6'd0);
        queue_search(5'd0);
        queue_search(5'd17);

        write_vertex_count(6'd63);
        queue_search(5'd31);

        write_vertex_count(6'd1);
        queue_search(5'd0);
        queue_search(5'd1);

        write_vertex_count(6'd32);
        queue_random_phase(35);

        write_vertex_count(count_t'($urandom_range(2, 31)));
        queue_random_phase(35);

        // fan out from vertex 0 to every vertex for the longest search
        write_vertex_count(count_t'($urandom_range(33, 63)));
        queue_load(5'd0, '1);
        queue_search(5'd0);
        queue_random_phase(35);

        write_vertex_count(6'd1);
        queue_random_phase(30);

        write_vertex_count(count_t'($urandom_range(2, 8)));
        queue_random_phase(35);

        write_vertex_count(6'd32);
        queue_random_phase(20);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && visits_due.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
